@@ hw/rtl/assert_macros.svh @@
// Assertion helpers: clocked on clk, quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/clp_pkg.sv @@
`default_nettype none
package clp_pkg;

  // normal components are Q2.14
  localparam int NORM_FRAC = 14;
  // dot product sum and plane distance widths
  localparam int AW = 52;
  localparam int DW = 48;
  // shared multiplier operand and product widths
  localparam int MA = 34;
  localparam int MB = 26;
  localparam int PW = MA + MB;

  localparam logic [2:0] CFG_NX  = 3'd0;
  localparam logic [2:0] CFG_NY  = 3'd1;
  localparam logic [2:0] CFG_NZ  = 3'd2;
  localparam logic [2:0] CFG_OFF = 3'd3;
  localparam logic [2:0] CFG_TOL = 3'd4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               valid;
    logic               last;
    logic [6:0]         count;
    logic               ovf;
  } clp_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DMUL, ST_DACC, ST_DIST, ST_EDGE, ST_TQ, ST_DIV,
    ST_XSUB, ST_XMUL, ST_XADD, ST_PUSHC, ST_PUSHB, ST_NEXT, ST_FIN
  } clp_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/plane_polygon_clip_top.sv @@
`default_nettype none
// channel | handshake           | payload
// in      | in_tvalid/in_tready | in_tdata x,y,z; in_tlast last_vertex
// out     | out_tvalid/out_tready | out_tdata x,y,z,count; out_tuser valid,ovf; out_tlast
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
// The plane distance of a vertex takes three passes through the shared multiplier,
// one accumulate and one offset subtract; then each crossing edge finds t, with the
// divider when t lies strictly between 0 and 1, and interpolates, and each point is
// pushed and each edge closed in turn.
// in_tready is high only while the sequencer is idle; a stalled output holds it in a push.
// Reset is synchronous on rst_n and restores the register defaults; cfg is always ready.
module plane_polygon_clip_top import clp_pkg::*; #(
  parameter int MAX_POINTS      = 64,
  parameter int COORD_FRAC_BITS = 14
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // vertex_x, vertex_y, vertex_z
  input  wire logic         in_tlast,   // last_vertex
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // out_x, out_y, out_z, point_count, pad
  output logic [1:0]        out_tuser,  // point_valid, overflow
  output logic              out_tlast,  // last_point
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = COORD_FRAC_BITS + 1;
  localparam logic [TW-1:0] ONE  = TW'(1) << COORD_FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (COORD_FRAC_BITS - 1);

  clp_state_t state_r, state_nxt;

  logic signed [15:0] nx_r, ny_r, nz_r;
  logic signed [31:0] off_r;
  logic [15:0]        tol_r;

  logic signed [31:0] v_r [3];
  logic signed [31:0] first_r [3];
  logic signed [31:0] prev_r [3];
  logic signed [31:0] c_r [3];
  logic signed [DW-1:0] dv_r, fd_r, pd_r, num_r, den_r;
  logic signed [AW-1:0] acc_r;
  logic        last_r, havef_r, drop_r, edge_r, pushb_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    k_r;
  logic [TW-1:0] tq_r;
  logic [32:0]   mag_r;

  clp_item_t pend_r, out_r, new_item, fin_item;
  logic      pend_v_r, out_v_r;

  // edge operands: main edge prev->v, closing edge v->first
  logic signed [31:0]   ea [3];
  logic signed [31:0]   eb [3];
  logic signed [DW-1:0] eda, edb, dist_c, den_c;
  logic                 ina, inb;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [32:0]   delta;
  logic [PW-1:0]        rr;

  logic div_start, div_done;
  logic [COORD_FRAC_BITS-1:0] div_q;

  logic out_free, full, push_st, push_take, push_go, fin_go;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ea[i] = edge_r ? v_r[i] : prev_r[i];
      eb[i] = edge_r ? first_r[i] : v_r[i];
    end
  end
  assign eda    = edge_r ? dv_r : pd_r;
  assign edb    = edge_r ? fd_r : dv_r;
  assign ina    = eda <= $signed({{(DW-16){1'b0}}, tol_r});
  assign inb    = edb <= $signed({{(DW-16){1'b0}}, tol_r});
  assign den_c  = eda - edb;
  assign dist_c = DW'(acc_r >>> NORM_FRAC) - DW'(off_r);
  assign delta  = 33'(eb[k_r]) - 33'(ea[k_r]);
  assign rr     = (PW'(prod) + HALF) >> COORD_FRAC_BITS;

  always_comb begin
    if (state_r == ST_XMUL) begin
      mul_a = MA'({1'b0, mag_r});
      mul_b = MB'({1'b0, tq_r});
    end else begin
      mul_a = MA'(v_r[k_r]);
      unique case (k_r)
        2'd0:    mul_b = MB'(nx_r);
        2'd1:    mul_b = MB'(ny_r);
        default: mul_b = MB'(nz_r);
      endcase
    end
  end

  clp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  clp_div #(.NW(DW), .QW(COORD_FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(num_r), .den(den_r), .done_r(div_done), .q_r(div_q)
  );

  // push and flush handshakes with the pending/output register pair
  assign out_free  = !out_v_r || out_tready;
  assign full      = cnt_r >= CW'(MAX_POINTS);
  assign push_st   = (state_r == ST_PUSHC) || (state_r == ST_PUSHB);
  assign push_go   = push_st && (full || !pend_v_r || out_free);
  assign push_take = push_go && !full;
  assign fin_go    = (state_r == ST_FIN) && (!(pend_v_r || last_r) || out_free);

  always_comb begin
    new_item       = '0;
    new_item.x     = (state_r == ST_PUSHC) ? c_r[0] : eb[0];
    new_item.y     = (state_r == ST_PUSHC) ? c_r[1] : eb[1];
    new_item.z     = (state_r == ST_PUSHC) ? c_r[2] : eb[2];
    new_item.valid = 1'b1;
    new_item.count = 7'(cnt_r + 1'b1);
    new_item.ovf   = drop_r;
    if (pend_v_r) begin
      fin_item      = pend_r;
      fin_item.last = last_r;
    end else begin
      fin_item       = '0;
      fin_item.last  = 1'b1;
      fin_item.count = 7'(cnt_r);
      fin_item.ovf   = drop_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DMUL;
      ST_DMUL:  if (k_r == 2'd2) state_nxt = ST_DACC;
      ST_DACC:  state_nxt = ST_DIST;
      ST_DIST: begin
        if (havef_r || last_r) state_nxt = ST_EDGE;
        else state_nxt = ST_FIN;
      end
      ST_EDGE: begin
        if (ina && inb) state_nxt = ST_PUSHB;
        else if (ina != inb) state_nxt = ST_TQ;
        else state_nxt = ST_NEXT;
      end
      ST_TQ: begin
        if (num_r <= 0 || num_r >= den_r) begin
          state_nxt = ST_XSUB;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:   if (div_done) state_nxt = ST_XSUB;
      ST_XSUB:  state_nxt = ST_XMUL;
      ST_XMUL:  state_nxt = ST_XADD;
      ST_XADD:  state_nxt = (k_r == 2'd2) ? ST_PUSHC : ST_XSUB;
      ST_PUSHC: if (push_go) state_nxt = pushb_r ? ST_PUSHB : ST_NEXT;
      ST_PUSHB: if (push_go) state_nxt = ST_NEXT;
      ST_NEXT:  state_nxt = (!edge_r && last_r) ? ST_EDGE : ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= 16'sd16384;
      off_r <= '0;
      tol_r <= 16'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NX:  nx_r  <= cfg_data[15:0];
        CFG_NY:  ny_r  <= cfg_data[15:0];
        CFG_NZ:  nz_r  <= cfg_data[15:0];
        CFG_OFF: off_r <= cfg_data;
        CFG_TOL: tol_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // polygon control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      havef_r <= 1'b0;
      drop_r  <= 1'b0;
      cnt_r   <= '0;
      edge_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          k_r    <= '0;
          edge_r <= 1'b0;
        end
        ST_DMUL: k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        ST_DIST: begin
          if (!havef_r) begin
            havef_r <= 1'b1;
            cnt_r   <= '0;
            drop_r  <= 1'b0;
          end
          if (havef_r == 1'b0 && last_r) edge_r <= 1'b1;
        end
        ST_XADD: k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        ST_PUSHC, ST_PUSHB: begin
          if (push_go && full) drop_r <= 1'b1;
          if (push_take) cnt_r <= cnt_r + 1'b1;
        end
        ST_NEXT: if (!edge_r && last_r) edge_r <= 1'b1;
        ST_FIN:  if (fin_go && last_r) havef_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        v_r[0] <= in_tdata[31:0];
        v_r[1] <= in_tdata[63:32];
        v_r[2] <= in_tdata[95:64];
        last_r <= in_tlast;
        acc_r  <= '0;
      end
      ST_DMUL: if (k_r != 2'd0) acc_r <= acc_r + AW'(prod);
      ST_DACC: acc_r <= acc_r + AW'(prod);
      ST_DIST: begin
        dv_r <= dist_c;
        if (!havef_r) begin
          first_r <= v_r;
          fd_r    <= dist_c;
        end
      end
      ST_EDGE: begin
        pushb_r <= inb;
        if (den_c < 0) begin
          num_r <= -eda;
          den_r <= -den_c;
        end else begin
          num_r <= eda;
          den_r <= den_c;
        end
      end
      ST_TQ: tq_r <= (num_r <= 0) ? '0 : ONE;
      ST_DIV: if (div_done) tq_r <= {1'b0, div_q};
      ST_XSUB: begin
        neg_r <= delta < 0;
        mag_r <= (delta < 0) ? 33'(-delta) : 33'(delta);
      end
      ST_XADD: c_r[k_r] <= neg_r ? ea[k_r] - 32'(rr) : ea[k_r] + 32'(rr);
      ST_FIN: if (fin_go) begin
        prev_r <= v_r;
        pd_r   <= dv_r;
      end
      default: ;
    endcase
  end

  // pending item and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if ((push_take && pend_v_r) || (fin_go && (pend_v_r || last_r))) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      if (push_take) begin
        pend_v_r <= 1'b1;
      end else if (fin_go && (pend_v_r || last_r)) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_take) begin
      if (pend_v_r) out_r <= pend_r;
      pend_r <= new_item;
    end
    if (fin_go && (pend_v_r || last_r)) out_r <= fin_item;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r.count, out_r.z, out_r.y, out_r.x};
  assign out_tuser  = {out_r.ovf, out_r.valid};
  assign out_tlast  = out_r.last;

`include "assert_macros.svh"
  `CLP_ASSERT_NOW(a_idle_empty, in_tvalid && in_tready, !pend_v_r, "vertex taken with a point pending")
  `CLP_ASSERT_NOW(a_marker_last, out_tvalid && !out_tuser[0], out_tlast, "empty marker not last")
  `CLP_ASSERT_NOW(a_cnt_cap, 1'b1, cnt_r <= CW'(MAX_POINTS), "point count past capacity")
  `CLP_ASSERT_NEXT(a_div_tq, div_done, tq_r < ONE, "divider quotient not below one")

endmodule
`default_nettype wire

@@ hw/rtl/clp_mul.sv @@
`default_nettype none
module clp_mul import clp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic signed [MA-1:0] a,
  input  wire logic signed [MB-1:0] b,
  output logic signed [PW-1:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

@@ hw/rtl/clp_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle. Requires num < den.
module clp_div #(
  parameter int NW = 48,
  parameter int QW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [NW-1:0] den,
  output logic               done_r,
  output logic [QW-1:0]      q_r
);
  localparam int CW = $clog2(QW + 1);

  logic [NW:0]   rem_r;
  logic [NW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [NW:0]   shl;
  logic          ge;

  assign shl = {rem_r[NW-1:0], 1'b0};
  assign ge  = shl >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (shl - {1'b0, den_r}) : shl;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

@@ sim/plane_polygon_clip_top_test.sv @@
`default_nettype none
module plane_polygon_clip_top_test;
  import clp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS   = 64;
  localparam int FRAC      = 14;
  localparam int DRAIN_CYC = 120;

  class clip_scoreboard;
    logic signed [15:0] nx, ny, nz;
    logic signed [31:0] offset;
    logic [15:0]        tol;
    longint             first_v[3], prev_v[3];
    longint             first_d, prev_d;
    int unsigned        emitted;
    bit                 have_first, dropped;
    clp_item_t          pending[$];
    clp_item_t          step_q[$];
    int                 errors;
    int                 points_seen;
    int                 polygons;

    function new();
      nx = 0; ny = 0; nz = 16384; offset = 0; tol = 16;
      have_first = 0; dropped = 0; emitted = 0;
      first_d = 0; prev_d = 0;
      errors = 0; points_seen = 0; polygons = 0;
      for (int i = 0; i < 3; i++) begin
        first_v[i] = 0; prev_v[i] = 0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_NX:  nx = val[15:0];
        CFG_NY:  ny = val[15:0];
        CFG_NZ:  nz = val[15:0];
        CFG_OFF: offset = val;
        CFG_TOL: tol = val[15:0];
        default: ;
      endcase
    endfunction

    function longint plane_dist(longint v[3]);
      longint dot;
      dot = longint'(nx) * v[0] + longint'(ny) * v[1] + longint'(nz) * v[2];
      // arithmetic shift floors toward minus infinity
      return (dot >>> NORM_FRAC) - longint'(offset);
    endfunction

    function void put_point(longint p[3], bit valid);
      clp_item_t it;
      it.x = valid ? p[0][31:0] : '0;
      it.y = valid ? p[1][31:0] : '0;
      it.z = valid ? p[2][31:0] : '0;
      it.valid = valid;
      it.last = 0;
      it.count = emitted[6:0];
      it.ovf = dropped;
      step_q.push_back(it);
    endfunction

    function void emit_point(longint p[3]);
      if (emitted >= MAX_PTS) begin
        dropped = 1;
        return;
      end
      emitted++;
      put_point(p, 1);
    endfunction

    function void clip_edge(longint a[3], longint da, longint b[3], longint db);
      bit ina, inb;
      longint num, den, tq, delta, mag, r;
      longint c[3];
      ina = da <= longint'(tol);
      inb = db <= longint'(tol);
      if (ina && inb) begin
        emit_point(b);
      end else if (ina != inb) begin
        num = da;
        den = da - db;
        if (den < 0) begin
          num = -num; den = -den;
        end
        if (num <= 0) tq = 0;
        else if (num >= den) tq = longint'(1) << FRAC;
        else tq = (num << FRAC) / den;
        for (int i = 0; i < 3; i++) begin
          delta = b[i] - a[i];
          mag = (delta < 0) ? -delta : delta;
          r = (mag * tq + (longint'(1) << (FRAC - 1))) >> FRAC;
          c[i] = (delta < 0) ? a[i] - r : a[i] + r;
        end
        emit_point(c);
        if (inb) emit_point(b);
      end
    endfunction

    function void note_vertex(logic [95:0] data, logic last);
      longint v[3];
      longint dv;
      v[0] = longint'($signed(data[31:0]));
      v[1] = longint'($signed(data[63:32]));
      v[2] = longint'($signed(data[95:64]));
      dv = plane_dist(v);
      step_q.delete();
      if (!have_first) begin
        first_v = v;
        first_d = dv;
        emitted = 0;
        dropped = 0;
        have_first = 1;
      end else begin
        clip_edge(prev_v, prev_d, v, dv);
      end
      prev_v = v;
      prev_d = dv;
      if (last) begin
        clip_edge(prev_v, prev_d, first_v, first_d);
        if (step_q.size() == 0) put_point(v, 0);
        step_q[step_q.size() - 1].last = 1;
        have_first = 0;
        polygons++;
      end
      foreach (step_q[i]) pending.push_back(step_q[i]);
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endfunction

    function void check_point(clp_item_t got);
      clp_item_t want;
      points_seen++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word, x", got.x, 0);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report_mismatch("x", got.x, want.x);
      if (got.y !== want.y) report_mismatch("y", got.y, want.y);
      if (got.z !== want.z) report_mismatch("z", got.z, want.z);
      if (got.valid !== want.valid) report_mismatch("valid", got.valid, want.valid);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      if (got.count !== want.count) report_mismatch("count", got.count, want.count);
      if (got.ovf !== want.ovf) report_mismatch("overflow", got.ovf, want.ovf);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;    // vertex_x, vertex_y, vertex_z
  logic         in_tlast = 0;     // last_vertex
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [103:0] out_tdata;        // out_x, out_y, out_z, point_count, pad
  logic [1:0]   out_tuser;        // point_valid, overflow
  logic         out_tlast;        // last_point
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  clip_scoreboard sb = new();
  int tx_idle_pct = 34;
  int rx_idle_pct = 67;
  int rx_hold_req = 0;
  int rx_hold = 0;
  int sent = 0;

  plane_polygon_clip_top #(.MAX_POINTS(MAX_PTS), .COORD_FRAC_BITS(FRAC)) u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready = 0;
    end else begin
      out_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    clp_item_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_vertex(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[31:0];
        got.y = out_tdata[63:32];
        got.z = out_tdata[95:64];
        got.count = out_tdata[102:96];
        got.valid = out_tuser[0];
        got.ovf = out_tuser[1];
        got.last = out_tlast;
        sb.check_point(got);
      end
    end
  end

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {z, y, x};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 0;
    sent++;
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic settle();
    in_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    if (sel < 85) return 32'($signed($urandom_range(0, 64)) - 32);
    return $urandom;
  endfunction

  task automatic random_polygons(int count);
    int nv;
    while (count > 0) begin
      nv = $urandom_range(1, 8);
      for (int i = 0; i < nv; i++)
        send_vertex(rand_coord(), rand_coord(), rand_coord(), i == nv - 1);
      count -= nv;
    end
  endtask

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // default plane z <= 16
    send_vertex(0, 0, 0, 1);                          // lone vertex inside
    send_vertex(0, 0, 32'h0010_0000, 1);              // lone vertex outside: empty
    send_vertex(0, 0, -100, 0);
    send_vertex(100, 0, -100, 0);
    send_vertex(0, 100, -50, 1);                      // all inside
    send_vertex(0, 0, -65536, 0);
    send_vertex(65536, 0, 65536, 0);
    send_vertex(0, 65536, -16384, 1);                 // leaves and enters
    send_vertex(0, 0, 500, 0);
    send_vertex(10, 0, 600, 0);
    send_vertex(0, 10, 700, 1);                       // all outside
    send_vertex(0, 0, 8, 0);
    send_vertex(100, 0, 30, 0);
    send_vertex(0, 0, -5, 1);                         // starts in tolerance band
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_vertex(32'hffff_ffff, 32'h0000_0000, 32'h0000_0010, 1);
    random_polygons(28);
    settle();

    write_cfg(CFG_NX, -16384);
    write_cfg(CFG_NY, 0);
    write_cfg(CFG_NZ, 0);
    write_cfg(CFG_OFF, 32'h8000_0000);
    write_cfg(CFG_TOL, 0);
    random_polygons(28);
    settle();

    tx_idle_pct = 67;
    rx_idle_pct = 34;
    write_cfg(CFG_NX, 16384);
    write_cfg(CFG_NY, 16384);
    write_cfg(CFG_NZ, -16384);
    write_cfg(CFG_OFF, 32'h7fff_ffff);
    write_cfg(CFG_TOL, 16'hffff);
    // everything inside: runs past the point capacity
    for (int i = 0; i < 70; i++)
      send_vertex($urandom_range(0, 2 ** 16), $urandom_range(0, 2 ** 16), 0, i == 69);
    settle();
    write_cfg(CFG_OFF, 0);
    random_polygons(28);
    settle();

    write_cfg(CFG_NX, $urandom_range(0, 32768) - 16384);
    write_cfg(CFG_NY, $urandom_range(0, 32768) - 16384);
    write_cfg(CFG_NZ, $urandom_range(0, 32768) - 16384);
    write_cfg(CFG_OFF, $urandom_range(0, 2 ** 16) - 2 ** 15);
    write_cfg(CFG_TOL, $urandom_range(0, 65535));
    rx_hold_req = 400;
    random_polygons(28);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_cfg(CFG_NX, 0);
    write_cfg(CFG_NY, 0);
    write_cfg(CFG_NZ, 16384);
    write_cfg(3'd5, 32'hdead_beef);
    write_cfg(3'd7, 32'h1234_5678);
    write_cfg(CFG_TOL, 16);
    random_polygons(28);
    settle();

    write_cfg(CFG_NX, 11585);
    write_cfg(CFG_NY, -11585);
    write_cfg(CFG_NZ, 0);
    write_cfg(CFG_OFF, 12345);
    write_cfg(CFG_TOL, 0);
    random_polygons(28);
    settle();

    $display("covered %0d vertices in %0d polygons, %0d result words checked",
             sent, sb.polygons, sb.points_seen);
    $display("planes: reset default, axis extremes, random normals, capacity overflow");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
